// ----- rtl/bmn_pkg.sv -----
// ----------------------------------------------------------------------------
// bmn_pkg
// Shared types, constants and state encodings of the Beeman step block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmn_pkg;

  localparam int DATA_WIDTH       = 32;
  localparam int FRAC_BITS        = 16;
  localparam int IDX_W            = 6;
  localparam int DT_W             = 32;
  localparam int MAX_ELEMENTS_DEF = 64;

  localparam logic [DT_W-1:0] DT_RESET  = 32'h0001_0000;
  localparam logic [63:0]     CLAMP_MAG = 64'h4000_0000_0000_0000;

  localparam logic [1:0] REQ_PRIME = 2'd0;
  localparam logic [1:0] REQ_PRED  = 2'd1;
  localparam logic [1:0] REQ_CORR  = 2'd2;

  typedef logic signed [63:0]           bmn_wide_t;
  typedef logic signed [DATA_WIDTH-1:0] bmn_data_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] element_index;
    bmn_data_t        acceleration;
    bmn_data_t        velocity_in;
    bmn_data_t        position_in;
  } bmn_in_t;

  typedef struct packed {
    bmn_data_t velocity_out;
    bmn_data_t position_out;
    logic      saturated;
  } bmn_out_t;

  typedef struct packed {
    bmn_data_t saved_velocity;
    bmn_data_t current_accel_hist;
    bmn_data_t previous_accel_hist;
  } bmn_hist_t;

  // request to the scaling unit
  typedef struct packed {
    logic start;
    logic half;
    logic div6;
  } bmn_scale_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DV,
    ST_XT,
    ST_XDOT,
    ST_XP,
    ST_CORR
  } bmn_state_t;

  typedef enum logic [3:0] {
    U_IDLE,
    U_ABS,
    U_MLO,
    U_MHI,
    U_SUM,
    U_CLAMP,
    U_DIVLD,
    U_DIV,
    U_SIGN
  } bmn_ustate_t;

endpackage

`default_nettype wire

// ----- rtl/bmn_scale_unit.sv -----
// ----------------------------------------------------------------------------
// bmn_scale_unit
// Multi-cycle round(x * dt / 2^s) with clamp, optionally followed by a
// rounded divide by six. One shared 32x32 multiplier, 16 quotient bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmn_scale_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmn_pkg::bmn_scale_req_t     req,
  input  bmn_pkg::bmn_wide_t          x,
  input  logic [bmn_pkg::DT_W-1:0]    dt,
  output logic                        done,
  output bmn_pkg::bmn_wide_t          res
);

  import bmn_pkg::*;

  localparam int          DIV_DIGIT   = 16;
  localparam int          DIV_STEPS   = 64 / DIV_DIGIT;
  localparam int          CNT_W       = $clog2(DIV_STEPS);
  localparam logic [20:0] DIV6_RECIP  = 21'd683;
  localparam int          DIV6_SHIFT  = 12;

  bmn_ustate_t state_r, state_nxt;
  logic        done_r;

  bmn_wide_t   x_r;
  logic        half_r;
  logic        div_r;
  logic        neg_r;
  logic [63:0] mag_r;
  logic [63:0] p0_r;
  logic [63:0] p1_r;
  logic [95:0] acc_r;
  logic [63:0] q_r;
  logic [63:0] dvd_r;
  logic [2:0]  rem_r;
  logic [CNT_W-1:0] cnt_r;
  bmn_wide_t   res_r;

  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [95:0] rnd;
  logic [95:0] shifted;
  logic [63:0] magc;
  logic [10:0] step1, step2;

  // one radix-256 digit of a divide by six: remainder below six in, {q, r} out
  function automatic logic [10:0] div6_step(input logic [2:0] rem, input logic [7:0] dig);
    logic [10:0] num;
    logic [20:0] scaled;
    logic [7:0]  qd;
    logic [10:0] back;
    num    = {rem, dig};
    scaled = 21'(num) * DIV6_RECIP;
    qd     = scaled[DIV6_SHIFT+7:DIV6_SHIFT];
    back   = num - 11'(qd) * 11'd6;
    return {qd, back[2:0]};
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      U_IDLE:  if (req.start) state_nxt = U_ABS;
      U_ABS:   state_nxt = U_MLO;
      U_MLO:   state_nxt = U_MHI;
      U_MHI:   state_nxt = U_SUM;
      U_SUM:   state_nxt = U_CLAMP;
      U_CLAMP: state_nxt = div_r ? U_DIVLD : U_SIGN;
      U_DIVLD: state_nxt = U_DIV;
      U_DIV:   if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = U_SIGN;
      U_SIGN:  state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  always_comb begin
    mul_a   = (state_r == U_MHI) ? mag_r[63:32] : mag_r[31:0];
    prod    = mul_a * dt;
    rnd     = half_r ? (96'd1 << FRAC_BITS) : (96'd1 << (FRAC_BITS - 1));
    shifted = half_r ? (acc_r >> (FRAC_BITS + 1)) : (acc_r >> FRAC_BITS);
    magc    = (shifted > {32'd0, CLAMP_MAG}) ? CLAMP_MAG : shifted[63:0];
    step1   = div6_step(rem_r, dvd_r[63:56]);
    step2   = div6_step(step1[2:0], dvd_r[55:48]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == U_SIGN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          x_r    <= x;
          half_r <= req.half;
          div_r  <= req.div6;
        end
      end
      U_ABS: begin
        neg_r <= x_r[63];
        mag_r <= x_r[63] ? 64'(-x_r) : 64'(x_r);
      end
      U_MLO:   p0_r  <= prod;
      U_MHI:   p1_r  <= prod;
      U_SUM:   acc_r <= {p1_r, 32'd0} + {32'd0, p0_r} + rnd;
      U_CLAMP: q_r   <= magc;
      U_DIVLD: begin
        dvd_r <= q_r + 64'd3;
        rem_r <= 3'd0;
        cnt_r <= '0;
      end
      U_DIV: begin
        q_r   <= {q_r[63-DIV_DIGIT:0], step1[10:3], step2[10:3]};
        rem_r <= step2[2:0];
        dvd_r <= {dvd_r[63-DIV_DIGIT:0], DIV_DIGIT'(0)};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      U_SIGN:  res_r <= neg_r ? -$signed(q_r) : $signed(q_r);
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// ----- rtl/beeman_second_order_step.sv -----
// ----------------------------------------------------------------------------
// beeman_second_order_step
// Beeman predictor/corrector step for one state element per request, with
// per-element history held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     start, busy, in_data           taken when start && !busy
//  result    out_valid, out_data            one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_data written when valid && ready
//
//  For priming save and pass-through the result is loaded in the fetch state;
//  the corrector and predictor first wait on the scaling unit (shared 32x32
//  multiplier over low and high halves, divide by six at 16 bits a cycle),
//  used once by the corrector and three times in turn by the predictor.
//  The next request is taken in the strobe cycle.
//  Reset is synchronous; history memory is not cleared, dt_r returns to 1.0.
//  Results cannot be stalled; busy alone holds off new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module beeman_second_order_step #(
  parameter int unsigned MAX_ELEMENTS = bmn_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  bmn_pkg::bmn_in_t          in_data,
  output logic                      out_valid,
  output bmn_pkg::bmn_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bmn_pkg::DT_W-1:0]  cfg_data
);

  import bmn_pkg::*;

  localparam int unsigned AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned EXT_W = 13;
  localparam bmn_wide_t   VMAX  = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam bmn_wide_t   VMIN  = -VMAX - 64'sd1;

  bmn_hist_t mem [MAX_ELEMENTS];

  bmn_state_t state_r, state_nxt;
  logic       out_valid_r;
  logic [DT_W-1:0] dt_r;

  bmn_in_t    in_r;
  bmn_hist_t  rd_q;
  bmn_wide_t  dv_r;
  bmn_wide_t  xdot_r;
  bmn_out_t   out_data_r;

  logic       accept;
  logic [EXT_W-1:0] in_idx_ext, idx_ext;
  logic       idx_ok;

  bmn_wide_t  a_w, v_w, p_w, cur_w, prv_w, sv_w;
  bmn_wide_t  x_dv, x_t, x_c, xdot_nxt;
  logic [DATA_WIDTH:0] vclip_pred, pclip_pred, vclip_corr;

  logic           mem_we;
  bmn_hist_t      wr_entry;
  bmn_scale_req_t scl_req;
  bmn_wide_t      scl_x;
  logic           scl_done;
  bmn_wide_t      scl_res;
  logic           out_ld;
  bmn_out_t       out_nxt;
  logic           dv_ld;
  logic           xdot_ld;

  // saturate to the data range; {clipped, value}
  function automatic logic [DATA_WIDTH:0] clip_data(input bmn_wide_t v);
    logic [DATA_WIDTH:0] r;
    if (v > VMAX)      r = {1'b1, VMAX[DATA_WIDTH-1:0]};
    else if (v < VMIN) r = {1'b1, VMIN[DATA_WIDTH-1:0]};
    else               r = {1'b0, v[DATA_WIDTH-1:0]};
    return r;
  endfunction

  assign accept     = start && !busy;
  assign in_idx_ext = EXT_W'(in_data.element_index);
  assign idx_ext    = EXT_W'(in_r.element_index);
  assign idx_ok     = ({1'b0, idx_ext} < (EXT_W + 1)'(MAX_ELEMENTS));

  always_comb begin
    a_w   = 64'(in_r.acceleration);
    v_w   = 64'(in_r.velocity_in);
    p_w   = 64'(in_r.position_in);
    cur_w = 64'(rd_q.current_accel_hist);
    prv_w = 64'(rd_q.previous_accel_hist);
    sv_w  = 64'(rd_q.saved_velocity);
    x_dv  = (a_w <<< 1) + a_w - cur_w;
    x_t   = (a_w <<< 2) - cur_w;
    x_c   = (a_w <<< 1) + (cur_w <<< 2) + cur_w - prv_w;
    xdot_nxt   = v_w + scl_res;
    vclip_pred = clip_data(v_w + dv_r);
    pclip_pred = clip_data(p_w + scl_res);
    vclip_corr = clip_data(sv_w + scl_res);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_FETCH;
      ST_FETCH: begin
        if (!idx_ok) begin
          state_nxt = ST_IDLE;
        end else begin
          case (in_r.req_type)
            REQ_PRED: state_nxt = ST_DV;
            REQ_CORR: state_nxt = ST_CORR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DV:   if (scl_done) state_nxt = ST_XT;
      ST_XT:   if (scl_done) state_nxt = ST_XDOT;
      ST_XDOT: state_nxt = ST_XP;
      ST_XP:   if (scl_done) state_nxt = ST_IDLE;
      ST_CORR: if (scl_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we   = 1'b0;
    wr_entry = rd_q;
    scl_req  = '0;
    scl_x    = x_dv;
    out_ld   = 1'b0;
    out_nxt  = '{velocity_out: in_r.velocity_in, position_out: in_r.position_in,
                 saturated: 1'b0};
    dv_ld    = 1'b0;
    xdot_ld  = 1'b0;
    case (state_r)
      ST_FETCH: begin
        if (!idx_ok) begin
          out_ld = 1'b1;
        end else begin
          case (in_r.req_type)
            REQ_PRIME: begin
              mem_we   = 1'b1;
              wr_entry.current_accel_hist = in_r.acceleration;
              out_ld   = 1'b1;
            end
            REQ_PRED: begin
              mem_we   = 1'b1;
              wr_entry = '{saved_velocity: in_r.velocity_in,
                           current_accel_hist: in_r.acceleration,
                           previous_accel_hist: rd_q.current_accel_hist};
              scl_req  = '{start: 1'b1, half: 1'b1, div6: 1'b0};
              scl_x    = x_dv;
            end
            REQ_CORR: begin
              scl_req  = '{start: 1'b1, half: 1'b0, div6: 1'b1};
              scl_x    = x_c;
            end
            default: out_ld = 1'b1;
          endcase
        end
      end
      ST_DV: begin
        if (scl_done) begin
          dv_ld   = 1'b1;
          scl_req = '{start: 1'b1, half: 1'b0, div6: 1'b1};
          scl_x   = x_t;
        end
      end
      ST_XT: begin
        if (scl_done) xdot_ld = 1'b1;
      end
      ST_XDOT: begin
        scl_req = '{start: 1'b1, half: 1'b0, div6: 1'b0};
        scl_x   = xdot_r;
      end
      ST_XP: begin
        if (scl_done) begin
          out_ld  = 1'b1;
          out_nxt = '{velocity_out: vclip_pred[DATA_WIDTH-1:0],
                      position_out: pclip_pred[DATA_WIDTH-1:0],
                      saturated: vclip_pred[DATA_WIDTH] | pclip_pred[DATA_WIDTH]};
        end
      end
      ST_CORR: begin
        if (scl_done) begin
          out_ld  = 1'b1;
          out_nxt = '{velocity_out: vclip_corr[DATA_WIDTH-1:0],
                      position_out: in_r.position_in,
                      saturated: vclip_corr[DATA_WIDTH]};
        end
      end
      default: ;
    endcase
  end

  bmn_scale_unit u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scl_req),
    .x     (scl_x),
    .dt    (dt_r),
    .done  (scl_done),
    .res   (scl_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dt_r        <= DT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_ld;
      if (cfg_valid && cfg_ready) dt_r <= cfg_data;
    end
  end

  // history memory: read on acceptance, written back in the next cycle for priming and predictor requests
  always_ff @(posedge clk) begin
    if (accept) rd_q <= mem[in_idx_ext[AW-1:0]];
    if (mem_we) mem[idx_ext[AW-1:0]] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (accept)  in_r       <= in_data;
    if (dv_ld)   dv_r       <= scl_res;
    if (xdot_ld) xdot_r     <= xdot_nxt;
    if (out_ld)  out_data_r <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
